[rtl/core/framed_value_stack_top_defines.svh]
// Assertion macros for the framed value stack checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef FRAMED_VALUE_STACK_TOP_DEFINES_SVH
`define FRAMED_VALUE_STACK_TOP_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define FVS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define FVS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fvs_pkg.sv]
// Shared types and constants for the framed value stack.
// No dependencies.
package fvs_pkg;

  localparam int IndexW  = 13;
  localparam int ValueW  = 32;
  localparam int DataW   = 32;
  localparam int SlotW   = 13;

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_POP   = 3'd1,
    OP_READ  = 3'd2,
    OP_WRITE = 3'd3,
    OP_OPEN  = 3'd4,
    OP_CLOSE = 3'd5,
    OP_RESET = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INDEX     = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_NOFRAME   = 3'd4,
    ST_FRAMEOVF  = 3'd5
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [IndexW-1:0] index;
    logic [ValueW-1:0] value;
  } fvs_req_t;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic [SlotW-1:0] slot;
    status_e          status;
  } fvs_rsp_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic frame;
    logic capture;
  } fvs_cmd_t;

  typedef struct packed {
    logic need_slot;
    logic need_frame;
  } fvs_sts_t;

endpackage

[rtl/core/fvs_ctrl.sv]
// Sequencer for the framed value stack: accept, execute, memory waits, respond.
// Depends on fvs_pkg.
module fvs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  fvs_pkg::fvs_sts_t sts_i,
  output fvs_pkg::fvs_cmd_t cmd_o,
  output logic             busy_o,
  output logic             done_o
);
  import fvs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_FRAME,
    S_SLOT,
    S_DONE
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          if (sts_i.need_frame) begin
            state_q <= S_FRAME;
          end else if (sts_i.need_slot) begin
            state_q <= S_SLOT;
          end else begin
            state_q <= S_DONE;
            done_q  <= 1'b1;
          end
        end
        S_FRAME: begin
          state_q <= S_SLOT;
        end
        S_SLOT: begin
          state_q <= S_DONE;
          done_q  <= 1'b1;
        end
        S_DONE: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.load    = (state_q == S_IDLE) && start_i;
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.frame   = (state_q == S_FRAME);
    cmd_o.capture = (state_q == S_SLOT);
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

[rtl/core/fvs_dp.sv]
// Datapath for the framed value stack: slot memory, frame base memory, pointers.
// Depends on fvs_pkg.
module fvs_dp #(
  parameter int STACK_DEPTH = 8192,
  parameter int FRAME_DEPTH = 256,
  parameter int WORD_WIDTH  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fvs_pkg::fvs_cmd_t cmd_i,
  input  fvs_pkg::fvs_req_t req_i,
  output fvs_pkg::fvs_sts_t sts_o,
  output fvs_pkg::fvs_rsp_t rsp_o
);
  import fvs_pkg::*;

  localparam int TopW   = $clog2(STACK_DEPTH);
  localparam int FcW    = $clog2(FRAME_DEPTH + 1);
  localparam int FaW    = $clog2(FRAME_DEPTH);
  localparam int CmpW   = (TopW > IndexW) ? TopW : IndexW;
  localparam int TopMax = STACK_DEPTH - 1;

  fvs_req_t req_q;
  fvs_rsp_t res_q, res_d;
  logic [TopW-1:0] top_q, top_d;
  logic [FcW-1:0]  fc_q, fc_d;

  logic [WORD_WIDTH-1:0] slot_mem [STACK_DEPTH];
  logic [WORD_WIDTH-1:0] slot_rdata_q;
  logic [TopW-1:0]       frame_mem [FRAME_DEPTH];
  logic [TopW-1:0]       frame_rdata_q;

  logic                  slot_we, slot_re, frame_we, frame_re;
  logic [TopW-1:0]       slot_waddr, slot_raddr;
  logic [WORD_WIDTH-1:0] slot_wdata;
  logic [FaW-1:0]        frame_addr;

  logic            stack_full, frames_full, idx_bad;
  logic [TopW-1:0] top_dec;
  logic [FcW-1:0]  fc_dec;

  assign stack_full  = (top_q >= TopW'(TopMax));
  assign frames_full = (fc_q == FcW'(FRAME_DEPTH));
  assign idx_bad     = (CmpW'(req_q.index) >= CmpW'(top_q));
  assign top_dec     = top_q - 1'b1;
  assign fc_dec      = fc_q - 1'b1;

  always_comb begin
    res_d            = res_q;
    top_d            = top_q;
    fc_d             = fc_q;
    slot_we          = 1'b0;
    slot_re          = 1'b0;
    slot_waddr       = top_q;
    slot_raddr       = top_dec;
    slot_wdata       = WORD_WIDTH'(req_q.value);
    frame_we         = 1'b0;
    frame_re         = 1'b0;
    frame_addr       = fc_q[FaW-1:0];
    sts_o.need_slot  = 1'b0;
    sts_o.need_frame = 1'b0;

    if (cmd_i.exec) begin
      res_d.data   = '0;
      res_d.slot   = '0;
      res_d.status = ST_OK;
      unique case (req_q.op)
        OP_PUSH: begin
          if (stack_full) begin
            res_d.status = ST_OVERFLOW;
          end else begin
            slot_we    = 1'b1;
            res_d.slot = SlotW'(top_q);
            top_d      = top_q + 1'b1;
          end
        end
        OP_POP: begin
          if (top_q == '0) begin
            res_d.status = ST_UNDERFLOW;
          end else begin
            top_d           = top_dec;
            slot_re         = 1'b1;
            sts_o.need_slot = 1'b1;
          end
        end
        OP_READ: begin
          if (idx_bad) begin
            res_d.status = ST_INDEX;
          end else begin
            slot_re         = 1'b1;
            slot_raddr      = TopW'(req_q.index);
            sts_o.need_slot = 1'b1;
          end
        end
        OP_WRITE: begin
          if (idx_bad) begin
            res_d.status = ST_INDEX;
          end else begin
            slot_we    = 1'b1;
            slot_waddr = TopW'(req_q.index);
          end
        end
        OP_OPEN: begin
          if (frames_full) begin
            res_d.status = ST_FRAMEOVF;
          end else if (stack_full) begin
            res_d.status = ST_OVERFLOW;
          end else begin
            slot_we    = 1'b1;
            frame_we   = 1'b1;
            res_d.slot = SlotW'(top_q);
            top_d      = top_q + 1'b1;
            fc_d       = fc_q + 1'b1;
          end
        end
        OP_CLOSE: begin
          if (fc_q == '0) begin
            res_d.status = ST_NOFRAME;
          end else begin
            fc_d             = fc_dec;
            frame_re         = 1'b1;
            frame_addr       = fc_dec[FaW-1:0];
            sts_o.need_frame = 1'b1;
          end
        end
        OP_RESET: begin
          top_d = '0;
        end
        default: begin
          top_d = top_q;
        end
      endcase
    end

    if (cmd_i.frame) begin
      top_d      = frame_rdata_q;
      slot_re    = 1'b1;
      slot_raddr = frame_rdata_q;
    end

    if (cmd_i.capture) begin
      res_d.data = DataW'(slot_rdata_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      fc_q  <= '0;
    end else begin
      top_q <= top_d;
      fc_q  <= fc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rdata_q <= slot_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_we) begin
      frame_mem[frame_addr] <= top_q;
    end
    if (frame_re) begin
      frame_rdata_q <= frame_mem[frame_addr];
    end
  end

  assign rsp_o = res_q;

endmodule

[rtl/core/framed_value_stack_top.sv]
// Top level of the framed value stack: sequencer plus datapath.
// Depends on fvs_pkg, fvs_ctrl and fvs_dp.
//
//   channel   | ports                 | transfer
//   ----------+-----------------------+-------------------------------------
//   request   | start, busy, req_i    | start high while busy low
//   result    | done_o, rsp_o         | done_o high for one cycle
//
// Push, write, open frame, reset and any error: no memory wait before the result.
// Pop and read: a wait state for the registered slot memory read.
// Close frame: frame base read then slot read, both registered.
// Reset is asynchronous, active low; it empties both stacks, no clearing pass.
// The result cannot be stalled; busy stays high through the result cycle.
module framed_value_stack_top #(
  parameter int STACK_DEPTH = 8192,
  parameter int FRAME_DEPTH = 256,
  parameter int WORD_WIDTH  = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  fvs_pkg::fvs_req_t req_i,
  output logic              done_o,
  output fvs_pkg::fvs_rsp_t rsp_o
);
  import fvs_pkg::*;

  fvs_cmd_t cmd;
  fvs_sts_t sts;

  fvs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  fvs_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .FRAME_DEPTH (FRAME_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

[rtl/core/fvs_checker.sv]
// Port-level checks for the framed value stack, bound to the top level.
// Depends on fvs_pkg and framed_value_stack_top_defines.svh.
`include "framed_value_stack_top_defines.svh"

module fvs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              done_o,
  input fvs_pkg::fvs_rsp_t rsp_o
);
  import fvs_pkg::*;

  `FVS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `FVS_ASSERT_IMP(a_done_busy, done_o, busy, "result outside a transaction")
  `FVS_ASSERT_NXT(a_done_pulse, done_o, !done_o && !busy, "result not a single-cycle end")
  `FVS_ASSERT_IMP(a_err_zero, done_o && (rsp_o.status != ST_OK),
    (rsp_o.data == '0) && (rsp_o.slot == '0), "error result carries data")

endmodule

bind framed_value_stack_top fvs_checker u_fvs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
